// File: src/lss_pkg.sv
// Shared types and constants for the literal string substitute block.
package lss_pkg;

  // Fixed widths of the configuration port and the length registers.
  localparam int CFG_LEN_W  = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  typedef logic [7:0] byte_t;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_LOW    = 3'd1,
    REG_PATTERN_HIGH   = 3'd2,
    REG_REPLACE_LENGTH = 3'd3,
    REG_REPLACE_LOW    = 3'd4,
    REG_REPLACE_HIGH   = 3'd5,
    REG_GLOBAL_MODE    = 3'd6
  } reg_idx_t;

  // Commands from the sequencer to the window cells.
  typedef struct packed {
    logic shift;
    logic load;
    logic clear;
  } win_ctrl_t;

  // Status of the window back to the sequencer.
  typedef struct packed {
    byte_t head_byte;
    logic  all_match;
  } win_stat_t;

endpackage

// File: src/literal_string_substitute_core.sv
// Sequencing: an item is accepted in S_IDLE and then holds the sequencer while it passes
// decode, the steps it needs (flush, replacement, item byte, window check), the tail and a
// closing state; a stalled output can hold any step that emits a result.
// The last result of an item reaches the output register in the closing state.
// A new item is not taken while one is in progress; the next item is taken after the closing state.
// Reset (synchronous) empties the window, enables matching and clears all configuration to zero.
module literal_string_substitute_core
  import lss_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int MAX_REPLACE_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input requests.
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [7:0]            in_byte,
  input  logic                  has_byte,
  input  logic                  line_end,
  // Result requests.
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [7:0]            out_byte,
  output logic                  out_valid,
  output logic                  out_line_end,
  output logic                  last_of_run,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int RIDX_W = (MAX_REPLACE_BYTES > 1) ? $clog2(MAX_REPLACE_BYTES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FLUSH,
    S_REPL,
    S_BYTE,
    S_CHECK,
    S_TAIL,
    S_DONE
  } state_t;

  // Configuration registers.
  logic [CFG_LEN_W-1:0]  pattern_length;
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [CFG_LEN_W-1:0]  replace_length;
  logic [CFG_DATA_W-1:0] replace_low;
  logic [CFG_DATA_W-1:0] replace_high;
  logic                  global_mode;

  // Sequencer state.
  state_t               state;
  logic [CNT_W-1:0]     wc;
  logic                 matching_enabled;
  byte_t                item_byte;
  logic                 item_has;
  logic                 item_le;
  logic                 direct_repl;
  logic                 repl_to_byte;
  logic [CFG_LEN_W-1:0] ridx;

  // One pending result, held until we know whether it ends the run.
  logic  hold_full;
  byte_t hold_byte;
  logic  hold_valid;
  logic  hold_le;

  // Saturated lengths.
  logic [CFG_LEN_W-1:0] plen;
  logic [CFG_LEN_W-1:0] rlen;
  logic [CFG_LEN_W-1:0] wc_ext;

  assign plen   = (pattern_length > CFG_LEN_W'(MAX_PATTERN_BYTES)) ?
                  CFG_LEN_W'(MAX_PATTERN_BYTES) : pattern_length;
  assign rlen   = (replace_length > CFG_LEN_W'(MAX_REPLACE_BYTES)) ?
                  CFG_LEN_W'(MAX_REPLACE_BYTES) : replace_length;
  assign wc_ext = CFG_LEN_W'(wc);

  // Byte views of the pattern and replacement registers.
  byte_t pat_bytes [MAX_PATTERN_BYTES];
  byte_t rep_bytes [MAX_REPLACE_BYTES];

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_pat
    if (i < 8) begin : g_lo
      assign pat_bytes[i] = pattern_low[8*i +: 8];
    end else begin : g_hi
      assign pat_bytes[i] = pattern_high[8*(i-8) +: 8];
    end
  end

  for (genvar i = 0; i < MAX_REPLACE_BYTES; i++) begin : g_rep
    if (i < 8) begin : g_lo
      assign rep_bytes[i] = replace_low[8*i +: 8];
    end else begin : g_hi
      assign rep_bytes[i] = replace_high[8*(i-8) +: 8];
    end
  end

  // Window row.
  win_ctrl_t win_ctl;
  win_stat_t win_stat;

  lss_window #(
    .CELLS (MAX_PATTERN_BYTES)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .ctl       (win_ctl),
    .load_byte (item_byte),
    .pat_bytes (pat_bytes),
    .stat      (win_stat)
  );

  // The held window is a prefix of the pattern when all cells agree and it is not too long.
  logic is_prefix;
  assign is_prefix = win_stat.all_match && (wc_ext <= plen);

  // Result emission: a new result moves the held one on to the output register.
  logic  out_free;
  logic  emit_req;
  logic  push;
  byte_t emit_byte;
  logic  emit_valid;
  logic  emit_le;
  logic  res_load;

  assign out_free = !res_valid || res_ready;

  always_comb begin
    emit_req     = 1'b0;
    emit_byte    = win_stat.head_byte;
    emit_valid   = 1'b1;
    emit_le      = 1'b0;
    win_ctl      = '0;
    case (state)
      S_DECIDE: begin
        win_ctl.load = item_has && matching_enabled && (plen != '0);
      end
      S_FLUSH: begin
        emit_req = (wc != '0);
      end
      S_REPL: begin
        emit_req  = (ridx < rlen);
        emit_byte = rep_bytes[ridx[RIDX_W-1:0]];
      end
      S_BYTE: begin
        emit_req  = 1'b1;
        emit_byte = item_byte;
      end
      S_CHECK: begin
        emit_req      = (wc != '0) && !is_prefix;
        win_ctl.clear = (wc != '0) && is_prefix && (wc_ext == plen);
      end
      S_TAIL: begin
        if (item_le) begin
          emit_req = 1'b1;
          if (wc == '0) begin
            emit_byte  = 8'h00;
            emit_valid = 1'b0;
            emit_le    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    push = emit_req && (!hold_full || out_free);
    // Shifting happens whenever a window byte is sent out.
    win_ctl.shift = push && (state == S_FLUSH || state == S_CHECK ||
                             (state == S_TAIL && wc != '0));
  end

  // The output register takes the held result on a new push or at the closing cycle.
  assign res_load = hold_full && (push || (state == S_DONE && out_free));

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_low    <= '0;
      pattern_high   <= '0;
      replace_length <= '0;
      replace_low    <= '0;
      replace_high   <= '0;
      global_mode    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[CFG_LEN_W-1:0];
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_REPLACE_LENGTH: replace_length <= cfg_data[CFG_LEN_W-1:0];
        REG_REPLACE_LOW:    replace_low    <= cfg_data;
        REG_REPLACE_HIGH:   replace_high   <= cfg_data;
        REG_GLOBAL_MODE:    global_mode    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, hold stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      wc               <= '0;
      matching_enabled <= 1'b1;
      hold_full        <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end

      // A new result pushes the held one out as a result that is not the last.
      if (push) begin
        if (hold_full) begin
          out_byte     <= hold_byte;
          out_valid    <= hold_valid;
          out_line_end <= hold_le;
          last_of_run  <= 1'b0;
          res_valid    <= 1'b1;
        end
        hold_full  <= 1'b1;
        hold_byte  <= emit_byte;
        hold_valid <= emit_valid;
        hold_le    <= emit_le;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_byte <= in_byte;
            item_has  <= has_byte;
            item_le   <= line_end;
            state     <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!item_has) begin
            state <= S_TAIL;
          end else if (!matching_enabled) begin
            direct_repl <= 1'b0;
            state       <= S_FLUSH;
          end else if (plen == '0) begin
            direct_repl      <= 1'b1;
            matching_enabled <= global_mode;
            state            <= S_FLUSH;
          end else begin
            wc    <= wc + 1'b1;
            state <= S_CHECK;
          end
        end
        S_FLUSH: begin
          if (wc != '0) begin
            if (push) begin
              wc <= wc - 1'b1;
            end
          end else if (direct_repl) begin
            ridx         <= '0;
            repl_to_byte <= 1'b1;
            state        <= S_REPL;
          end else begin
            state <= S_BYTE;
          end
        end
        S_REPL: begin
          if (ridx < rlen) begin
            if (push) begin
              ridx <= ridx + 1'b1;
            end
          end else begin
            state <= repl_to_byte ? S_BYTE : S_TAIL;
          end
        end
        S_BYTE: begin
          if (push) begin
            state <= S_TAIL;
          end
        end
        S_CHECK: begin
          if (wc == '0) begin
            state <= S_TAIL;
          end else if (is_prefix) begin
            if (wc_ext == plen) begin
              wc               <= '0;
              matching_enabled <= global_mode;
              ridx             <= '0;
              repl_to_byte     <= 1'b0;
              state            <= S_REPL;
            end else begin
              state <= S_TAIL;
            end
          end else if (push) begin
            wc <= wc - 1'b1;
          end
        end
        S_TAIL: begin
          if (!item_le) begin
            state <= S_DONE;
          end else if (wc != '0) begin
            if (push) begin
              wc <= wc - 1'b1;
            end
          end else if (push) begin
            matching_enabled <= 1'b1;
            state            <= S_DONE;
          end
        end
        S_DONE: begin
          // The held result, if any, is the last one of this item.
          if (!hold_full) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_byte     <= hold_byte;
            out_valid    <= hold_valid;
            out_line_end <= hold_le;
            last_of_run  <= 1'b1;
            res_valid    <= 1'b1;
            hold_full    <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/lss_cell.sv
// One window cell: holds a pending byte and compares it to its pattern byte.
module lss_cell
  import lss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  win_ctrl_t ctl,
  input  logic      prev_valid,
  input  byte_t     next_byte,
  input  logic      next_valid,
  input  byte_t     load_byte,
  input  byte_t     pat_byte,
  output byte_t     cell_byte,
  output logic      cell_valid,
  output logic      match
);

  // A new byte lands in the first empty cell of the row.
  logic load_here;
  assign load_here = ctl.load && prev_valid && !cell_valid;

  // An empty cell never breaks the prefix.
  assign match = !cell_valid || (cell_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (ctl.clear) begin
      cell_valid <= 1'b0;
    end else if (ctl.shift) begin
      cell_valid <= next_valid;
    end else if (load_here) begin
      cell_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      cell_byte <= next_byte;
    end else if (load_here) begin
      cell_byte <= load_byte;
    end
  end

endmodule

// File: src/lss_window.sv
// Row of window cells that shifts toward the head one byte per cycle while ctl.shift is set.
module lss_window
  import lss_pkg::*;
#(
  parameter int CELLS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  win_ctrl_t ctl,
  input  byte_t     load_byte,
  input  byte_t     pat_bytes [CELLS],
  output win_stat_t stat
);

  byte_t            cell_byte  [CELLS];
  logic [CELLS-1:0] cell_valid;
  logic [CELLS-1:0] match;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    byte_t nb;
    logic  nv;
    logic  pv;

    // The tail cell takes an empty slot on a shift.
    if (i == CELLS - 1) begin : g_tail
      assign nb = 8'h00;
      assign nv = 1'b0;
    end else begin : g_mid
      assign nb = cell_byte[i+1];
      assign nv = cell_valid[i+1];
    end

    if (i == 0) begin : g_head
      assign pv = 1'b1;
    end else begin : g_body
      assign pv = cell_valid[i-1];
    end

    lss_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (pv),
      .next_byte  (nb),
      .next_valid (nv),
      .load_byte  (load_byte),
      .pat_byte   (pat_bytes[i]),
      .cell_byte  (cell_byte[i]),
      .cell_valid (cell_valid[i]),
      .match      (match[i])
    );
  end

  assign stat.head_byte = cell_byte[0];
  assign stat.all_match = &match;

endmodule
